// ===== design/rep_pkg.sv =====
// Shared types and constants for the rate extrapolation predictor.
package rep_pkg;

  localparam int FRACTION_BITS_DEF = 16;

  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HORIZON = 3'd0,
    REG_GAIN    = 3'd1,
    REG_CLAMP   = 3'd2,
    REG_MIN     = 3'd3,
    REG_MAX     = 3'd4
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_RATE,
    ST_MUL,
    ST_ACC,
    ST_FIN
  } state_t;

  // multiply steps of the shared unit, in issue order
  typedef enum logic [2:0] {
    OP_AVG_OLD  = 3'd0,
    OP_AVG_RATE = 3'd1,
    OP_BL_AVG   = 3'd2,
    OP_BL_RATE  = 3'd3,
    OP_EXT      = 3'd4
  } op_t;

endpackage

// ===== design/rate_extrapolation_predictor.sv =====
// Rate extrapolation predictor: serial divider plus one shared multiplier.
//
// Input channel (in_valid / in_stall) carries a sample, its time step and a
// restart flag; the result channel (out_valid / out_stall) carries the
// predicted value. A request is accepted when valid is high and stall low.
// The config port writes one register per cycle at cfg_index while cfg_we is
// high; write only while the block is idle.
//
// From input accept to result valid the block runs 33 + FRACTION_BITS divider
// steps, one bit per cycle, forms the rate, runs five multiply/accumulate
// pairs on the shared multiplier (32 x 25 bit at the default) and then
// saturates and clamps. One item is in work at a time and the next request
// is taken the cycle after the result is registered.
//
// The result sits in an output register; the next request is taken while it
// waits. If the receiver still stalls when the following result is ready,
// the block holds in its final step until the register frees up.
// Synchronous reset clears state, the rate history and the config registers.
module rate_extrapolation_predictor
  import rep_pkg::*;
#(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic signed [31:0]   in_sample,
  input  logic [23:0]          in_time_step,
  input  logic                 in_restart,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [31:0]   out_predicted,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_wdata
);

  localparam int BW  = ((FRACTION_BITS + 1 > 24) ? FRACTION_BITS + 1 : 24) + 1;
  localparam int PW  = 32 + BW;
  localparam int AW  = PW + 2;
  localparam int QW  = 33 + FRACTION_BITS;
  localparam int CW  = $clog2(QW);
  localparam logic [BW-1:0] ONE_B = BW'(1) << FRACTION_BITS;
  localparam logic [CW-1:0] DIV_LAST = CW'(QW - 1);

  function automatic logic signed [31:0] sat32(input logic signed [AW-1:0] x);
    logic in_range;
    in_range = (&x[AW-1:31]) | ~(|x[AW-1:31]);
    if (in_range) return x[31:0];
    else if (x[AW-1]) return 32'sh8000_0000;
    else return 32'sh7fff_ffff;
  endfunction

  state_t state_r, state_nxt;
  op_t    op_r, op_nxt;

  logic [23:0]        horizon_r;
  logic [16:0]        gain_r;
  logic               clamp_en_r;
  logic signed [31:0] min_r, max_r;

  logic signed [31:0] prev_r, prev_nxt;
  logic signed [31:0] avg_r, avg_nxt;
  logic signed [31:0] sample_r, sample_nxt;
  logic [23:0]        dt_r, dt_nxt;
  logic               neg_r, neg_nxt;
  logic [23:0]        rem_r, rem_nxt;
  logic [QW-1:0]      quo_r, quo_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic signed [31:0] rate_r, rate_nxt;
  logic signed [31:0] blend_r, blend_nxt;
  logic signed [PW-1:0] prod_r, prod_nxt;
  logic signed [AW-1:0] acc_r, acc_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic signed [31:0] out_r, out_nxt;

  logic               in_acc;
  logic signed [31:0] base;
  logic signed [32:0] diff;
  logic [32:0]        mag;
  logic [24:0]        div_try;
  logic               div_ge;
  logic               q_big;
  logic signed [31:0] mul_a;
  logic signed [BW-1:0] mul_b;
  logic [BW-1:0]      dt_ext, g_ext, g_sat, h_ext;
  logic               dt_lt_one;
  logic signed [AW-1:0] acc_sum;
  logic signed [31:0] sum_sat;
  logic signed [31:0] res;
  logic               out_free;

  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // ---------------- next state ----------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_DIV;
      ST_DIV:  if (cnt_r == '0) state_nxt = ST_RATE;
      ST_RATE: state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_ACC;
      ST_ACC:  state_nxt = (op_r == OP_EXT) ? ST_FIN : ST_MUL;
      ST_FIN:  if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // ---------------- outputs ----------------
  always_comb begin
    in_stall      = (state_r != ST_IDLE);
    out_valid     = out_valid_r;
    out_predicted = out_r;
  end

  // ---------------- datapath ----------------
  always_comb begin
    dt_ext    = {{(BW-24){1'b0}}, dt_r};
    g_ext     = {{(BW-17){1'b0}}, gain_r};
    h_ext     = {{(BW-24){1'b0}}, horizon_r};
    g_sat     = (g_ext > ONE_B) ? ONE_B : g_ext;
    dt_lt_one = dt_ext < ONE_B;

    base = in_restart ? in_sample : prev_r;
    diff = $signed({in_sample[31], in_sample}) - $signed({base[31], base});
    mag  = diff[32] ? 33'(-diff) : 33'(diff);

    div_try = {rem_r, quo_r[QW-1]};
    div_ge  = div_try >= {1'b0, dt_r};
    q_big   = |quo_r[QW-1:31];

    case (op_r)
      OP_AVG_OLD:  begin mul_a = avg_r;   mul_b = $signed(ONE_B - dt_ext); end
      OP_AVG_RATE: begin mul_a = rate_r;  mul_b = $signed(dt_ext);         end
      OP_BL_AVG:   begin mul_a = avg_r;   mul_b = $signed(ONE_B - g_sat);  end
      OP_BL_RATE:  begin mul_a = rate_r;  mul_b = $signed(g_sat);          end
      OP_EXT:      begin mul_a = blend_r; mul_b = $signed(h_ext);          end
      default:     begin mul_a = '0;      mul_b = '0;                      end
    endcase

    acc_sum = acc_r + AW'(prod_r);
    // arithmetic shift gives the floor
    sum_sat = sat32(acc_sum >>> FRACTION_BITS);

    res = sat32(acc_r >>> FRACTION_BITS);
    if (clamp_en_r) begin
      if (res < min_r) res = min_r;
      if (res > max_r) res = max_r;
    end

    prev_nxt      = prev_r;
    avg_nxt       = avg_r;
    sample_nxt    = sample_r;
    dt_nxt        = dt_r;
    neg_nxt       = neg_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    cnt_nxt       = cnt_r;
    rate_nxt      = rate_r;
    blend_nxt     = blend_r;
    prod_nxt      = prod_r;
    acc_nxt       = acc_r;
    op_nxt        = op_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          sample_nxt = in_sample;
          dt_nxt     = (in_time_step == '0) ? 24'd1 : in_time_step;
          prev_nxt   = in_sample;
          neg_nxt    = diff[32];
          rem_nxt    = '0;
          quo_nxt    = {mag, {FRACTION_BITS{1'b0}}};
          cnt_nxt    = DIV_LAST;
        end
      end
      ST_DIV: begin
        rem_nxt = div_ge ? 24'(div_try - {1'b0, dt_r}) : div_try[23:0];
        quo_nxt = {quo_r[QW-2:0], div_ge};
        cnt_nxt = cnt_r - CW'(1);
      end
      ST_RATE: begin
        if (neg_r) rate_nxt = q_big ? 32'sh8000_0000 : -$signed(quo_r[31:0]);
        else       rate_nxt = q_big ? 32'sh7fff_ffff : $signed(quo_r[31:0]);
        acc_nxt = '0;
        op_nxt  = OP_AVG_OLD;
      end
      ST_MUL: begin
        prod_nxt = mul_a * mul_b;
      end
      ST_ACC: begin
        case (op_r)
          OP_AVG_OLD: begin
            acc_nxt = acc_sum;
            op_nxt  = OP_AVG_RATE;
          end
          OP_AVG_RATE: begin
            avg_nxt = dt_lt_one ? sum_sat : rate_r;
            acc_nxt = '0;
            op_nxt  = OP_BL_AVG;
          end
          OP_BL_AVG: begin
            acc_nxt = acc_sum;
            op_nxt  = OP_BL_RATE;
          end
          OP_BL_RATE: begin
            blend_nxt = sum_sat;
            // sample folded in ahead of the shift: floor is unchanged
            acc_nxt   = $signed({{(AW-32){sample_r[31]}}, sample_r}) <<< FRACTION_BITS;
            op_nxt    = OP_EXT;
          end
          OP_EXT: begin
            acc_nxt = acc_sum;
          end
          default: ;
        endcase
      end
      ST_FIN: begin
        if (out_free) begin
          out_nxt       = res;
          out_valid_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      op_r        <= OP_AVG_OLD;
      out_valid_r <= 1'b0;
      prev_r      <= '0;
      avg_r       <= '0;
      horizon_r   <= '0;
      gain_r      <= '0;
      clamp_en_r  <= 1'b0;
      min_r       <= 32'sh8000_0000;
      max_r       <= 32'sh7fff_ffff;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      out_valid_r <= out_valid_nxt;
      prev_r      <= prev_nxt;
      avg_r       <= avg_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_HORIZON: horizon_r  <= cfg_wdata[23:0];
          REG_GAIN:    gain_r     <= cfg_wdata[16:0];
          REG_CLAMP:   clamp_en_r <= cfg_wdata[0];
          REG_MIN:     min_r      <= $signed(cfg_wdata);
          REG_MAX:     max_r      <= $signed(cfg_wdata);
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    sample_r <= sample_nxt;
    dt_r     <= dt_nxt;
    neg_r    <= neg_nxt;
    rem_r    <= rem_nxt;
    quo_r    <= quo_nxt;
    cnt_r    <= cnt_nxt;
    rate_r   <= rate_nxt;
    blend_r  <= blend_nxt;
    prod_r   <= prod_nxt;
    acc_r    <= acc_nxt;
    out_r    <= out_nxt;
  end

endmodule

// ===== design/rep_checker.sv =====
// Port-level checks for the rate extrapolation predictor, bound to the top level.
module rep_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_predicted
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_predicted))
    else $error("stalled result changed");

  // an accepted request keeps the block busy afterwards
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall ##1 in_stall)
    else $error("block free too soon after a request");

  // a new result only appears at the end of a busy period
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without work");

  // reset leaves the block idle with no result pending
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("not idle after reset");

endmodule

bind rate_extrapolation_predictor rep_checker u_rep_checker (.*);

// ===== dv/tb_rate_extrapolation_predictor.sv =====
// Self-checking testbench for the rate extrapolation predictor: random and directed requests.
`timescale 1ns / 1ps

module tb_rate_extrapolation_predictor
  import rep_pkg::*;
();

  localparam int     CLK_HALF     = 10;
  localparam longint TIMEOUT_NS   = 64'd20_000_000;
  localparam int     TAIL_CYCLES  = 150;
  localparam int     HOLD_CYCLES  = 600;
  localparam int     RAND_PHASES  = 8;
  localparam int     PHASE_ITEMS  = 170;
  localparam int     HOLD_PHASE   = 4;
  localparam int     PAUSE_PHASE  = 5;
  localparam int     MAX_PRINTS   = 100;

  localparam longint ONE_FX    = longint'(1) << FRACTION_BITS_DEF;
  localparam longint RATE_CAP  = longint'(1) << 32;
  localparam longint Q_MAX     = (longint'(1) << 31) - 1;
  localparam longint Q_MIN     = -(longint'(1) << 31);
  localparam int     S_MAX     = 32'sh7FFF_FFFF;
  localparam int     S_MIN     = 32'sh8000_0000;
  localparam logic [23:0] ONE_STEP = 24'(ONE_FX);
  localparam logic [23:0] STEP_MAX = 24'hFF_FFFF;
  localparam logic [16:0] GAIN_ONE = 17'(ONE_FX);
  localparam logic [16:0] GAIN_MAX = 17'h1_FFFF;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = 3'd7;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    logic signed [31:0] sample;
    logic [23:0]        time_step;
    logic               restart;
  } sample_req_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic signed [31:0]   in_sample = '0;
  logic [23:0]          in_time_step = '0;
  logic                 in_restart = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic signed [31:0]   out_predicted;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_HORIZON;
  logic [31:0]          cfg_wdata = '0;

  rate_extrapolation_predictor u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_sample    (in_sample),
    .in_time_step (in_time_step),
    .in_restart   (in_restart),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_predicted(out_predicted),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  always #CLK_HALF clk = ~clk;

  // requests waiting to be driven, predictions waiting for their result
  sample_req_t sample_reqs[$];
  int          want_predictions[$];

  // predictor copy of the block's registers and history
  logic [23:0] horizon_m = '0;
  logic [16:0] gain_m = '0;
  logic        clamp_m = 1'b0;
  int          lo_m = S_MIN;
  int          hi_m = S_MAX;
  int          prev_sample_m = 0;
  int          avg_rate_m = 0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int holds_asked = 0;
  int err_cnt = 0;
  int accepted_cnt = 0;
  int checked_cnt = 0;

  function automatic int sat32(longint x);
    if (x > Q_MAX) return int'(Q_MAX);
    if (x < Q_MIN) return int'(Q_MIN);
    return int'(x);
  endfunction

  // predicted value for one sample; advances the rate history
  function automatic int extrapolate(int s, logic [23:0] ts, logic rs);
    longint dt, diff, mag, q, rate, g, blend, hz, res;
    dt = ts;
    if (dt == 0) dt = 1;
    if (rs) prev_sample_m = s;
    diff = longint'(s) - longint'(prev_sample_m);
    mag = (diff < 0) ? -diff : diff;
    q = (mag << FRACTION_BITS_DEF) / dt;
    if (q > RATE_CAP) q = RATE_CAP;
    rate = sat32((diff < 0) ? -q : q);
    if (dt < ONE_FX)
      avg_rate_m = sat32(((ONE_FX - dt) * avg_rate_m + rate * dt) >>> FRACTION_BITS_DEF);
    else
      avg_rate_m = int'(rate);
    g = gain_m;
    if (g > ONE_FX) g = ONE_FX;
    blend = sat32(((ONE_FX - g) * avg_rate_m + g * rate) >>> FRACTION_BITS_DEF);
    hz = horizon_m;
    res = sat32(longint'(s) + ((blend * hz) >>> FRACTION_BITS_DEF));
    if (clamp_m) begin
      // min first, so max wins when the limits cross
      if (res < lo_m) res = lo_m;
      if (res > hi_m) res = hi_m;
    end
    prev_sample_m = s;
    return int'(res);
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    err_cnt++;
    if (err_cnt <= MAX_PRINTS)
      $display("MISMATCH @%0t %s: got %h want %h", $time, what, got, want);
  endtask

  // driver: offers the next request once the current one is taken
  always @(posedge clk) begin : drv
    sample_req_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        want_predictions = {want_predictions,
                            extrapolate(in_sample, in_time_step, in_restart)};
        accepted_cnt++;
      end
      if (!in_valid || !in_stall) begin
        if (sample_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = sample_reqs.pop_front();
          in_valid     <= 1'b1;
          in_sample    <= nxt.sample;
          in_time_step <= nxt.time_step;
          in_restart   <= nxt.restart;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks results and drives the receiver stall, incl. the long hold
  always @(posedge clk) begin : mon
    int hold_left;
    int holds_done;
    int want;
    if (!rst_n) begin
      out_stall  <= 1'b0;
      hold_left  = 0;
      holds_done = 0;
    end else begin
      if (out_valid && !out_stall) begin
        checked_cnt++;
        if (want_predictions.size() == 0) begin
          report_mismatch("result with no request pending", out_predicted, '0);
        end else begin
          want = want_predictions.pop_front();
          if (out_predicted !== want)
            report_mismatch("predicted", out_predicted, want);
        end
      end
      if (holds_done != holds_asked) begin
        holds_done++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    @(negedge clk);
    case (idx)
      REG_HORIZON: horizon_m = data[23:0];
      REG_GAIN:    gain_m = data[16:0];
      REG_CLAMP:   clamp_m = data[0];
      REG_MIN:     lo_m = data;
      REG_MAX:     hi_m = data;
      default: ;
    endcase
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (sample_reqs.size() != 0 || in_valid || want_predictions.size() != 0);
  endtask

  task automatic queue_req(int s, logic [23:0] ts, logic rs);
    sample_req_t r;
    r.sample    = s;
    r.time_step = ts;
    r.restart   = rs;
    sample_reqs = {sample_reqs, r};
  endtask

  function automatic logic [23:0] pick_step();
    case ($urandom_range(9))
      0, 1, 2, 3, 4: return 24'($urandom_range(1, ONE_STEP - 1));
      5:             return 24'($urandom_range(ONE_STEP, 24'h3F_FFFF));
      6:             return 24'($urandom());
      7:             return 24'($urandom_range(1, 16));
      8:             return ONE_STEP;
      default:       return ONE_STEP - 1;
    endcase
  endfunction

  // well-formed track: restart, then a noisy ramp with plausible steps
  task automatic queue_track(int n);
    longint level, slope;
    int k;
    level = longint'($signed($urandom())) >>> $urandom_range(0, 12);
    slope = longint'($signed($urandom())) >>> $urandom_range(6, 24);
    for (k = 0; k < n; k++) begin
      level = sat32(level + slope + (longint'($signed($urandom())) >>> 20));
      queue_req(int'(level), pick_step(), k == 0);
    end
  endtask

  task automatic queue_noise();
    logic [23:0] ts;
    ts = ($urandom_range(15) == 0) ? '0 : 24'($urandom());
    queue_req($urandom(), ts, 1'($urandom()));
  endtask

  task automatic queue_mix(int n);
    int left, len;
    left = n;
    while (left > 0) begin
      if ($urandom_range(9) < 8) begin
        len = $urandom_range(4, 40);
        if (len > left) len = left;
        queue_track(len);
      end else begin
        len = 1;
        queue_noise();
      end
      left -= len;
    end
  endtask

  task automatic set_idling(idle_mode_t mode);
    case (mode)
      IDLE_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      IDLE_SENDER:   begin send_idle_pct = 64; recv_stall_pct = 0;  end
      IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 64; end
      default:       begin send_idle_pct = 14; recv_stall_pct = 14; end
    endcase
  endtask

  task automatic randomise_config();
    logic [23:0] hz;
    logic [16:0] g;
    int a, b;
    case ($urandom_range(3))
      0:       hz = '0;
      1:       hz = STEP_MAX;
      2:       hz = 24'($urandom_range(1, 24'h4_0000));
      default: hz = 24'($urandom());
    endcase
    case ($urandom_range(3))
      0:       g = '0;
      1:       g = GAIN_ONE;
      2:       g = GAIN_MAX;
      default: g = 17'($urandom());
    endcase
    a = $urandom();
    b = $urandom();
    case ($urandom_range(3))
      0: if (a > b) begin a = a ^ b; b = a ^ b; a = a ^ b; end
      1: if (a < b) begin a = a ^ b; b = a ^ b; a = a ^ b; end
      2: begin a = S_MIN; b = S_MAX; end
      default: begin b = $urandom_range(0, 32'h00FF_FFFF); a = -b; end
    endcase
    write_reg(REG_HORIZON, {8'($urandom()), hz});
    write_reg(REG_GAIN, {15'($urandom()), g});
    write_reg(REG_CLAMP, {31'($urandom()), 1'($urandom())});
    write_reg(REG_MIN, a);
    write_reg(REG_MAX, b);
    write_reg(3'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)), $urandom());
  endtask

  initial begin : stim
    int ph;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: extreme samples and steps, unit horizon, half gain
    write_reg(REG_HORIZON, ONE_STEP);
    write_reg(REG_GAIN, 32'h8000);
    write_reg(REG_CLAMP, '0);
    queue_req(S_MAX, ONE_STEP, 1'b1);
    queue_req(S_MIN, 24'd1, 1'b0);
    queue_req(S_MAX, '0, 1'b0);
    queue_req(0, STEP_MAX, 1'b0);
    queue_req(32'h1234_0000, ONE_STEP - 1, 1'b1);
    queue_req(32'h1235_0000, 24'h00_8000, 1'b0);
    queue_req(-1, ONE_STEP, 1'b0);
    queue_req(32'h5555_5555, 24'hAA_AAAA, 1'b0);
    queue_req(32'hAAAA_AAAA, 24'h55_5555, 1'b1);
    wait_drained();

    // gain above one, full horizon, crossed limits, unmapped register
    write_reg(REG_HORIZON, STEP_MAX);
    write_reg(REG_GAIN, GAIN_MAX);
    write_reg(REG_CLAMP, 32'd1);
    write_reg(REG_MIN, 32'h0001_0000);
    write_reg(REG_MAX, 32'hFFFF_0000);
    write_reg(REG_SPARE_LAST, 32'hFFFF_FFFF);
    queue_req(0, ONE_STEP, 1'b1);
    queue_req(S_MAX, 24'd1, 1'b0);
    queue_req(S_MIN, 24'd1, 1'b0);
    queue_req(32'h100, 24'h02_0000, 1'b0);
    queue_req(32'h4000_0000, '0, 1'b1);
    wait_drained();

    // ordinary clamp window, averaged rate only
    write_reg(REG_HORIZON, ONE_STEP);
    write_reg(REG_GAIN, '0);
    write_reg(REG_MIN, -32'sh0010_0000);
    write_reg(REG_MAX, 32'sh0010_0000);
    queue_track(6);
    wait_drained();

    for (ph = 0; ph < RAND_PHASES; ph++) begin
      randomise_config();
      set_idling(idle_mode_t'(ph % 4));
      queue_mix(PHASE_ITEMS / 2);
      if (ph == HOLD_PHASE) holds_asked++;
      if (ph == PAUSE_PHASE) wait_drained();
      queue_mix(PHASE_ITEMS - PHASE_ITEMS / 2);
      wait_drained();
    end

    set_idling(IDLE_NONE);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (want_predictions.size() != 0)
      report_mismatch("predictions never answered", want_predictions.size(), '0);
    $display("covered %0d requests over %0d random and 3 directed setups", accepted_cnt,
             RAND_PHASES);
    $display("%0d results checked, %0d mismatches", checked_cnt, err_cnt);
    if (err_cnt == 0)
      $display("rate_extrapolation_predictor regression: pass");
    else
      $display("rate_extrapolation_predictor regression: fail");
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("timeout with %0d predictions outstanding", want_predictions.size());
    $display("rate_extrapolation_predictor regression: fail");
    $finish;
  end

endmodule

// ===== sim.f =====
design/rep_pkg.sv
design/rate_extrapolation_predictor.sv
design/rep_checker.sv
dv/tb_rate_extrapolation_predictor.sv
